// ===== src/tclc_pkg.sv =====
`default_nettype none

package tclc_pkg;

  // Field widths
  localparam int COUNT_W = 16;
  localparam int LUX_W = 28;
  localparam int LUX_FRAC = 16;

  // Parameter defaults for the top level
  localparam int DEF_POW_TABLE_DEPTH = 64;
  localparam int DEF_FRAC_BITS = 16;

  // Segment codes
  localparam int SEG_W = 3;
  localparam logic [SEG_W-1:0] SEG_NO_LIGHT = 3'd0;
  localparam logic [SEG_W-1:0] SEG_POW = 3'd1;
  localparam logic [SEG_W-1:0] SEG_LIN1 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_LIN2 = 3'd3;
  localparam logic [SEG_W-1:0] SEG_LIN3 = 3'd4;
  localparam logic [SEG_W-1:0] SEG_ABOVE = 3'd5;

  // Ratio bounds, scaled by 100
  localparam int CMP_W = 24;
  localparam int RATIO_SCALE = 100;
  localparam int BOUND_POW = 52;
  localparam int BOUND_LIN1 = 65;
  localparam int BOUND_LIN2 = 80;
  localparam int BOUND_LIN3 = 130;

  // Linear segment coefficients, scaled by 100000
  localparam int COEF_W = 12;
  localparam int LIN_W = COEF_W + COUNT_W;
  localparam logic [COEF_W-1:0] LIN1_A = 12'd2290;
  localparam logic [COEF_W-1:0] LIN1_B = 12'd2910;
  localparam logic [COEF_W-1:0] LIN2_A = 12'd1570;
  localparam logic [COEF_W-1:0] LIN2_B = 12'd1800;
  localparam logic [COEF_W-1:0] LIN3_A = 12'd338;
  localparam logic [COEF_W-1:0] LIN3_B = 12'd260;

  // Power segment: 3150*2^30 - 5930*p, then times ch0 and down by 2^14
  localparam int Q30_W = 31;
  localparam int SUB_W = 44;
  localparam int D_W = 42;
  localparam int DSPLIT = D_W / 2;
  localparam int PP_W = COUNT_W + DSPLIT;
  localparam int FULL_W = COUNT_W + D_W;
  localparam int POW_SHIFT = 14;
  localparam logic [SUB_W-1:0] POW_COEF = 44'd5930;
  localparam logic [SUB_W-1:0] POW_BASE = 44'd3150 << 30;

  // Final divide by 100000
  localparam int DIVIDEND_W = LIN_W + LUX_FRAC;
  localparam int LUX_DIV_W = 17;
  localparam logic [LUX_DIV_W-1:0] LUX_DIVISOR = 17'd100000;

  // 100000 = 2^5 * 3125: shift out 2^5, then multiply by ceil(2^49 / 3125).
  // The rounding excess is 563, so the top bits are exact for any 39-bit value.
  localparam int LUX_PRE_SHIFT = 5;
  localparam int SCALED_W = DIVIDEND_W - LUX_PRE_SHIFT;
  localparam int RECIP_W = 38;
  localparam int RECIP_SHIFT = 49;
  localparam logic [RECIP_W-1:0] LUX_RECIP = 38'd180143985095;
  localparam int M_SPLIT = 20;
  localparam int R_SPLIT = 19;
  localparam int LUX_STAGES = 3;

  // Stages between the ratio divider and the lux scaling
  localparam int BACK_STAGES = 7;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;
  } sample_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux_q16;
    logic no_light_flag;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;
    logic [SEG_W-1:0] seg;
  } class_item_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Truncating Q30 product
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // Q30 power with n factors
  function automatic logic [63:0] qpow(input logic [63:0] v, input int n);
    logic [63:0] r;
    r = v;
    for (int i = 1; i < n; i++) begin
      r = qmul(r, v);
    end
    return r;
  endfunction

  // Largest y in [0, 1] (Q30) with y^5 <= x^7, used at elaboration only
  function automatic logic [Q30_W-1:0] pow_entry(input logic [63:0] x);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    target = qpow(x, 7);
    lo = 64'd0;
    hi = Q30_ONE;
    for (int s = 0; s < 32; s++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (qpow(mid, 5) <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo[Q30_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/tclc_front.sv =====
`default_nettype none

module tclc_front
  import tclc_pkg::*;
(
  input  sample_t     sample,
  output class_item_t item
);

  logic [CMP_W-1:0] ir_scaled;
  logic [CMP_W-1:0] bb_pow;
  logic [CMP_W-1:0] bb_lin1;
  logic [CMP_W-1:0] bb_lin2;
  logic [CMP_W-1:0] bb_lin3;

  // Ratio bounds as exact integer compares
  assign ir_scaled = CMP_W'(sample.infrared_count) * CMP_W'(RATIO_SCALE);
  assign bb_pow = CMP_W'(sample.broadband_count) * CMP_W'(BOUND_POW);
  assign bb_lin1 = CMP_W'(sample.broadband_count) * CMP_W'(BOUND_LIN1);
  assign bb_lin2 = CMP_W'(sample.broadband_count) * CMP_W'(BOUND_LIN2);
  assign bb_lin3 = CMP_W'(sample.broadband_count) * CMP_W'(BOUND_LIN3);

  // Segment pick, each segment closed at its upper bound
  always_comb begin
    item.broadband_count = sample.broadband_count;
    item.infrared_count = sample.infrared_count;
    if (sample.broadband_count == '0) begin
      item.seg = SEG_NO_LIGHT;
    end else if (ir_scaled <= bb_pow) begin
      item.seg = SEG_POW;
    end else if (ir_scaled <= bb_lin1) begin
      item.seg = SEG_LIN1;
    end else if (ir_scaled <= bb_lin2) begin
      item.seg = SEG_LIN2;
    end else if (ir_scaled <= bb_lin3) begin
      item.seg = SEG_LIN3;
    end else begin
      item.seg = SEG_ABOVE;
    end
  end

endmodule

`default_nettype wire

// ===== src/tclc_queue.sv =====
`default_nettype none

module tclc_queue
  import tclc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  class_item_t push_item,
  output logic        full,
  input  logic        pop,
  output class_item_t pop_item,
  output logic        empty
);

  class_item_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  assign pop_item = mem[rd_ptr];
  assign full = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

endmodule

`default_nettype wire

// ===== src/tclc_pipe_div.sv =====
`default_nettype none

module tclc_pipe_div #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  // Stage outputs; remainder, pending bits and divisor stop one stage early
  logic          vld  [QW];
  logic [QW-1:0] quo  [QW];
  logic [SW-1:0] side [QW];
  logic [DW-1:0] rem  [QW-1];
  logic [QW-1:0] low  [QW-1];
  logic [DW-1:0] dvs  [QW-1];

  // One quotient bit per stage, restoring
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_cur;
    logic [DW-1:0] r_cur;
    logic [QW-1:0] l_cur;
    logic [DW-1:0] d_cur;
    logic [QW-1:0] q_cur;
    logic [SW-1:0] s_cur;
    logic [DW:0]   trial;
    logic          fits;
    logic          v_q;
    logic [QW-1:0] q_q;
    logic [SW-1:0] s_q;

    if (k == 0) begin : g_first
      assign v_cur = in_valid;
      assign r_cur = rem_in;
      assign l_cur = low_in;
      assign d_cur = divisor;
      assign q_cur = '0;
      assign s_cur = side_in;
    end else begin : g_next
      assign v_cur = vld[k-1];
      assign r_cur = rem[k-1];
      assign l_cur = low[k-1];
      assign d_cur = dvs[k-1];
      assign q_cur = quo[k-1];
      assign s_cur = side[k-1];
    end

    assign trial = {r_cur, l_cur[QW-1]};
    assign fits = (trial >= {1'b0, d_cur});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else begin
        v_q <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      q_q <= {q_cur[QW-2:0], fits};
      s_q <= s_cur;
    end

    assign vld[k] = v_q;
    assign quo[k] = q_q;
    assign side[k] = s_q;

    if (k < QW - 1) begin : g_carry
      logic [DW-1:0] r_q;
      logic [QW-1:0] l_q;
      logic [DW-1:0] d_q;

      always_ff @(posedge clk) begin
        r_q <= fits ? DW'(trial - {1'b0, d_cur}) : trial[DW-1:0];
        l_q <= {l_cur[QW-2:0], 1'b0};
        d_q <= d_cur;
      end

      assign rem[k] = r_q;
      assign low[k] = l_q;
      assign dvs[k] = d_q;
    end
  end

  assign out_valid = vld[QW-1];
  assign quotient = quo[QW-1];
  assign side_out = side[QW-1];

endmodule

`default_nettype wire

// ===== src/tclc_back.sv =====
`default_nettype none

module tclc_back
  import tclc_pkg::*;
#(
  parameter int POW_TABLE_DEPTH = DEF_POW_TABLE_DEPTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  class_item_t in_item,
  output logic        out_valid,
  output result_t     out_result
);

  localparam int IW = $clog2(POW_TABLE_DEPTH + 1);
  localparam int UW = FRAC_BITS + IW;
  localparam int PW = Q30_W + FRAC_BITS;
  localparam int ITEM_W = $bits(class_item_t);

  // Partial product widths for the lux scaling
  localparam int MH_W = SCALED_W - M_SPLIT;
  localparam int RH_W = RECIP_W - R_SPLIT;
  localparam int LL_W = M_SPLIT + R_SPLIT;
  localparam int HL_W = MH_W + R_SPLIT;
  localparam int LH_W = M_SPLIT + RH_W;
  localparam int HH_W = MH_W + RH_W;
  localparam int CROSS_W = LH_W + 1;
  localparam int PROD_W = SCALED_W + RECIP_W;

  // k^1.4 table, Q30, built at elaboration
  logic [Q30_W-1:0] pow_tab [POW_TABLE_DEPTH + 1];

  for (genvar i = 0; i <= POW_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [63:0] X = (64'(i) << 30) / POW_TABLE_DEPTH;
    assign pow_tab[i] = pow_entry(X);
  end

  // Ratio k = ch1/ch0 with FRAC_BITS fraction bits
  logic              kq_valid;
  logic [FRAC_BITS-1:0] kq;
  logic [ITEM_W-1:0] kq_side;
  class_item_t       kq_item;

  tclc_pipe_div #(
    .DW(COUNT_W),
    .QW(FRAC_BITS),
    .SW(ITEM_W)
  ) u_ratio_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .rem_in   (in_item.infrared_count),
    .low_in   ('0),
    .divisor  (in_item.broadband_count),
    .side_in  (in_item),
    .out_valid(kq_valid),
    .quotient (kq),
    .side_out (kq_side)
  );

  assign kq_item = class_item_t'(kq_side);

  // Stage 1 logic: table position and linear products
  logic [UW-1:0]     u_pos;
  logic [COEF_W-1:0] coef_a;
  logic [COEF_W-1:0] coef_b;

  assign u_pos = UW'(kq) * UW'(POW_TABLE_DEPTH);

  always_comb begin
    unique case (kq_item.seg)
      SEG_LIN1: begin
        coef_a = LIN1_A;
        coef_b = LIN1_B;
      end
      SEG_LIN2: begin
        coef_a = LIN2_A;
        coef_b = LIN2_B;
      end
      SEG_LIN3: begin
        coef_a = LIN3_A;
        coef_b = LIN3_B;
      end
      default: begin
        coef_a = '0;
        coef_b = '0;
      end
    endcase
  end

  // Pipeline registers
  logic [BACK_STAGES-1:0] vld;

  logic [IW-1:0]        s1_idx;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [LIN_W-1:0]     s1_pos;
  logic [LIN_W-1:0]     s1_neg;
  logic [COUNT_W-1:0]   s1_c0;
  logic [SEG_W-1:0]     s1_seg;

  logic [Q30_W-1:0]     s2_lo;
  logic [Q30_W-1:0]     s2_hi;
  logic [FRAC_BITS-1:0] s2_frac;
  logic [LIN_W-1:0]     s2_pos;
  logic [LIN_W-1:0]     s2_neg;
  logic [COUNT_W-1:0]   s2_c0;
  logic [SEG_W-1:0]     s2_seg;

  logic [Q30_W-1:0]   s3_lo;
  logic [PW-1:0]      s3_prod;
  logic [LIN_W-1:0]   s3_lin;
  logic [COUNT_W-1:0] s3_c0;
  logic [SEG_W-1:0]   s3_seg;

  logic [SUB_W-1:0]   s4_sub;
  logic [LIN_W-1:0]   s4_lin;
  logic [COUNT_W-1:0] s4_c0;
  logic [SEG_W-1:0]   s4_seg;

  logic [D_W-1:0]     s5_d;
  logic [LIN_W-1:0]   s5_lin;
  logic [COUNT_W-1:0] s5_c0;
  logic [SEG_W-1:0]   s5_seg;

  logic [PP_W-1:0]  s6_pp_lo;
  logic [PP_W-1:0]  s6_pp_hi;
  logic [LIN_W-1:0] s6_lin;
  logic [SEG_W-1:0] s6_seg;

  logic [DIVIDEND_W-1:0] s7_n;
  logic                  s7_flag;

  // Combinational pieces between stages
  logic [Q30_W-1:0]      tab_diff;
  logic [Q30_W:0]        p_sum;
  logic [FULL_W-1:0]     pow_full;
  logic [DIVIDEND_W-1:0] n_next;

  assign tab_diff = (s2_hi >= s2_lo) ? (s2_hi - s2_lo) : '0;
  assign p_sum = {1'b0, s3_lo} + {1'b0, s3_prod[PW-1:FRAC_BITS]};
  assign pow_full = (FULL_W'(s6_pp_hi) << DSPLIT) + FULL_W'(s6_pp_lo);

  // Dividend for the final divide by 100000
  always_comb begin
    unique case (s6_seg) inside
      SEG_POW:                      n_next = pow_full[FULL_W-1:POW_SHIFT];
      SEG_LIN1, SEG_LIN2, SEG_LIN3: n_next = {s6_lin, LUX_FRAC'(0)};
      default:                      n_next = '0;
    endcase
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BACK_STAGES-2:0], kq_valid};
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    s1_idx <= u_pos[UW-1:FRAC_BITS];
    s1_frac <= u_pos[FRAC_BITS-1:0];
    s1_pos <= LIN_W'(coef_a) * LIN_W'(kq_item.broadband_count);
    s1_neg <= LIN_W'(coef_b) * LIN_W'(kq_item.infrared_count);
    s1_c0 <= kq_item.broadband_count;
    s1_seg <= kq_item.seg;

    s2_lo <= pow_tab[s1_idx];
    s2_hi <= pow_tab[s1_idx + IW'(1)];
    s2_frac <= s1_frac;
    s2_pos <= s1_pos;
    s2_neg <= s1_neg;
    s2_c0 <= s1_c0;
    s2_seg <= s1_seg;

    s3_lo <= s2_lo;
    s3_prod <= PW'(tab_diff) * PW'(s2_frac);
    s3_lin <= (s2_pos > s2_neg) ? (s2_pos - s2_neg) : '0;
    s3_c0 <= s2_c0;
    s3_seg <= s2_seg;

    s4_sub <= POW_COEF * SUB_W'(p_sum[Q30_W-1:0]);
    s4_lin <= s3_lin;
    s4_c0 <= s3_c0;
    s4_seg <= s3_seg;

    s5_d <= (s4_sub < POW_BASE) ? D_W'(POW_BASE - s4_sub) : '0;
    s5_lin <= s4_lin;
    s5_c0 <= s4_c0;
    s5_seg <= s4_seg;

    s6_pp_lo <= PP_W'(s5_c0) * PP_W'(s5_d[DSPLIT-1:0]);
    s6_pp_hi <= PP_W'(s5_c0) * PP_W'(s5_d[D_W-1:DSPLIT]);
    s6_lin <= s5_lin;
    s6_seg <= s5_seg;

    s7_n <= n_next;
    s7_flag <= (s6_seg == SEG_NO_LIGHT);
  end

  // Lux = dividend / 100000: drop the factor of 32, then multiply by the
  // reciprocal of 3125 as four partial products and keep the top bits
  logic [LUX_STAGES-1:0] lvld;
  logic [SCALED_W-1:0]   lux_m;
  logic [LL_W-1:0]       l1_ll;
  logic [HL_W-1:0]       l1_hl;
  logic [LH_W-1:0]       l1_lh;
  logic [HH_W-1:0]       l1_hh;
  logic                  l1_flag;
  logic [LL_W-1:0]       l2_ll;
  logic [CROSS_W-1:0]    l2_cross;
  logic [HH_W-1:0]       l2_hh;
  logic                  l2_flag;
  logic [PROD_W-1:0]     lux_prod;
  logic                  lux_valid;
  logic [LUX_W-1:0]      lux_quo;
  logic                  lux_flag;

  assign lux_m = s7_n[DIVIDEND_W-1:LUX_PRE_SHIFT];
  assign lux_prod = (PROD_W'(l2_hh) << (M_SPLIT + R_SPLIT))
                  + (PROD_W'(l2_cross) << R_SPLIT)
                  + PROD_W'(l2_ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      lvld <= '0;
    end else begin
      lvld <= {lvld[LUX_STAGES-2:0], vld[BACK_STAGES-1]};
    end
  end

  always_ff @(posedge clk) begin
    l1_ll <= LL_W'(lux_m[M_SPLIT-1:0]) * LL_W'(LUX_RECIP[R_SPLIT-1:0]);
    l1_hl <= HL_W'(lux_m[SCALED_W-1:M_SPLIT]) * HL_W'(LUX_RECIP[R_SPLIT-1:0]);
    l1_lh <= LH_W'(lux_m[M_SPLIT-1:0]) * LH_W'(LUX_RECIP[RECIP_W-1:R_SPLIT]);
    l1_hh <= HH_W'(lux_m[SCALED_W-1:M_SPLIT]) * HH_W'(LUX_RECIP[RECIP_W-1:R_SPLIT]);
    l1_flag <= s7_flag;

    // cross terms aligned at 2^R_SPLIT
    l2_cross <= (CROSS_W'(l1_hl) << 1) + CROSS_W'(l1_lh);
    l2_ll <= l1_ll;
    l2_hh <= l1_hh;
    l2_flag <= l1_flag;

    lux_quo <= lux_prod[PROD_W-1:RECIP_SHIFT];
    lux_flag <= l2_flag;
  end

  assign lux_valid = lvld[LUX_STAGES-1];

  assign out_valid = lux_valid;
  assign out_result.lux_q16 = lux_quo;
  assign out_result.no_light_flag = lux_flag;

endmodule

`default_nettype wire

// ===== src/two_channel_lux_calculator.sv =====
// Two-channel lux calculator. Give it a broadband and an infrared count with
// start while busy is low; it takes one item every cycle, and each result
// shows on result with done high for exactly one cycle. Each item passes
// through the queue slot, the one-bit-per-stage ratio divider (FRAC_BITS
// stages), seven interpolation and multiply stages, and three stages that
// scale by 1/100000 through a reciprocal multiply. Results come out in input
// order and cannot be held off, so busy is high only during reset. A zero
// broadband count gives lux 0 with no_light_flag set; a ratio above 1.30
// gives lux 0 with the flag clear.
`default_nettype none

module two_channel_lux_calculator
  import tclc_pkg::*;
#(
  parameter int POW_TABLE_DEPTH = DEF_POW_TABLE_DEPTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  sample_t sample,
  output logic    done,
  output result_t result
);

  localparam int LATENCY = 1 + FRAC_BITS + BACK_STAGES + LUX_STAGES;

  class_item_t front_item;
  class_item_t head_item;
  logic        queue_full;
  logic        queue_empty;
  logic        accept;

  assign busy = queue_full || rst;
  assign accept = start && !busy;

  // Front: classify by ratio segment
  tclc_front u_front (
    .sample(sample),
    .item  (front_item)
  );

  tclc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_item(front_item),
    .full     (queue_full),
    .pop      (!queue_empty),
    .pop_item (head_item),
    .empty    (queue_empty)
  );

  // Back: ratio, interpolation and lux formula
  tclc_back #(
    .POW_TABLE_DEPTH(POW_TABLE_DEPTH),
    .FRAC_BITS      (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!queue_empty),
    .in_item   (head_item),
    .out_valid (done),
    .out_result(result)
  );

  // Every item taken comes out with a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("item accepted but no result after pipeline latency");

  // No result without a matching item taken earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching item");

  // No-light results always carry zero lux
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.no_light_flag) |-> (result.lux_q16 == '0))
    else $error("no-light result with nonzero lux");

endmodule

`default_nettype wire

// ===== tb/lux_result_check.sv =====
`timescale 1ns / 100ps

module lux_result_check
  import tclc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_POW_TABLE_DEPTH,
  parameter int RATIO_FRAC = DEF_FRAC_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  sample_t sample,
  input  logic    done,
  input  result_t result,
  output int      pending,
  output int      fail_count,
  output int      checked_count,
  output int      dark_hits,
  output int      curve_hits,
  output int      linear_hits,
  output int      cutoff_hits
);

  localparam bit [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    sample_t stim;
    result_t lux;
  } lux_due_t;

  // Expected results in input order
  lux_due_t lux_due[$];

  // k^1.4 samples in Q30, one more than the depth for the top end point
  bit [63:0] pow14_table [0:TABLE_DEPTH];

  // Truncating Q30 multiply
  function automatic bit [63:0] q30_mul(input bit [63:0] a, input bit [63:0] b);
    return (a * b) >> 30;
  endfunction

  // Q30 power: n factors of v
  function automatic bit [63:0] q30_pow(input bit [63:0] v, input int n);
    bit [63:0] acc;
    acc = v;
    for (int i = 1; i < n; i++) begin
      acc = q30_mul(acc, v);
    end
    return acc;
  endfunction

  // Each entry: largest y in [0, 1] with y^5 <= x^7
  initial begin
    bit [63:0] x;
    bit [63:0] goal;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] mid;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      x = (64'(i) * ONE_Q30) / 64'(TABLE_DEPTH);
      goal = q30_pow(x, 7);
      lo = 64'd0;
      hi = ONE_Q30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 64'd1) / 64'd2;
        if (q30_pow(mid, 5) <= goal) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      pow14_table[i] = lo;
    end
  end

  // Which formula the ratio ch1/ch0 selects; each segment closed at its top
  function automatic logic [SEG_W-1:0] ratio_segment(input bit [63:0] c0,
                                                     input bit [63:0] c1);
    if (c0 == 64'd0) return SEG_NO_LIGHT;
    if (64'(RATIO_SCALE) * c1 <= 64'(BOUND_POW) * c0) return SEG_POW;
    if (64'(RATIO_SCALE) * c1 <= 64'(BOUND_LIN1) * c0) return SEG_LIN1;
    if (64'(RATIO_SCALE) * c1 <= 64'(BOUND_LIN2) * c0) return SEG_LIN2;
    if (64'(RATIO_SCALE) * c1 <= 64'(BOUND_LIN3) * c0) return SEG_LIN3;
    return SEG_ABOVE;
  endfunction

  // Lux in Q16 for one sample
  function automatic result_t predict_lux(input sample_t s);
    bit [63:0] c0;
    bit [63:0] c1;
    bit [63:0] kq;
    bit [63:0] u;
    bit [63:0] idx;
    bit [63:0] f;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] p;
    bit [63:0] sub;
    bit [63:0] coef_a;
    bit [63:0] coef_b;
    bit [63:0] pos;
    bit [63:0] neg;
    bit [63:0] lux;
    result_t r;
    c0 = 64'(s.broadband_count);
    c1 = 64'(s.infrared_count);
    lux = 64'd0;
    r = '0;
    coef_a = 64'd0;
    coef_b = 64'd0;
    case (ratio_segment(c0, c1))
      SEG_NO_LIGHT: begin
        r.no_light_flag = 1'b1;
      end
      SEG_POW: begin
        // interpolate k^1.4 between table points
        kq = (c1 << RATIO_FRAC) / c0;
        u = kq * 64'(TABLE_DEPTH);
        idx = u >> RATIO_FRAC;
        f = u & ((64'd1 << RATIO_FRAC) - 64'd1);
        if (idx >= 64'(TABLE_DEPTH)) begin
          idx = 64'(TABLE_DEPTH) - 64'd1;
          f = 64'd1 << RATIO_FRAC;
        end
        lo = pow14_table[idx];
        hi = pow14_table[idx + 64'd1];
        p = (hi >= lo) ? lo + (((hi - lo) * f) >> RATIO_FRAC) : lo;
        sub = 64'(POW_COEF) * p;
        if (sub < 64'(POW_BASE)) begin
          lux = (c0 * (64'(POW_BASE) - sub)) / (64'(LUX_DIVISOR) << POW_SHIFT);
        end
      end
      SEG_LIN1, SEG_LIN2, SEG_LIN3: begin
        case (ratio_segment(c0, c1))
          SEG_LIN1: begin
            coef_a = 64'(LIN1_A);
            coef_b = 64'(LIN1_B);
          end
          SEG_LIN2: begin
            coef_a = 64'(LIN2_A);
            coef_b = 64'(LIN2_B);
          end
          default: begin
            coef_a = 64'(LIN3_A);
            coef_b = 64'(LIN3_B);
          end
        endcase
        pos = coef_a * c0;
        neg = coef_b * c1;
        // negative difference saturates to zero
        if (neg < pos) begin
          lux = ((pos - neg) << LUX_FRAC) / 64'(LUX_DIVISOR);
        end
      end
      default: ;
    endcase
    r.lux_q16 = lux[LUX_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input sample_t s,
                                 input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t mismatch, %s: ch0=%0d ch1=%0d expected %0d got %0d",
             $realtime, what, s.broadband_count, s.infrared_count, want, got);
    fail_count++;
  endtask

  // Compare results on the edge that ends their strobe, then log new items
  always @(posedge clk) begin : watch
    lux_due_t want;
    logic [SEG_W-1:0] seg;
    if (!rst && done) begin
      if (lux_due.size() == 0) begin
        report_mismatch("result with no item outstanding", '0, 0, result.lux_q16);
      end else begin
        want = lux_due.pop_front();
        checked_count++;
        if (result.lux_q16 !== want.lux.lux_q16) begin
          report_mismatch("lux_q16", want.stim, want.lux.lux_q16, result.lux_q16);
        end
        if (result.no_light_flag !== want.lux.no_light_flag) begin
          report_mismatch("no_light_flag", want.stim, want.lux.no_light_flag,
                          result.no_light_flag);
        end
      end
    end
    if (!rst && start && !busy) begin
      seg = ratio_segment(64'(sample.broadband_count), 64'(sample.infrared_count));
      case (seg)
        SEG_NO_LIGHT: dark_hits++;
        SEG_POW: curve_hits++;
        SEG_ABOVE: cutoff_hits++;
        default: linear_hits++;
      endcase
      lux_due.push_back('{stim: sample, lux: predict_lux(sample)});
    end
    pending = lux_due.size();
  end

endmodule

// ===== tb/two_channel_lux_calculator_tb.sv =====
`timescale 1ns / 100ps

module two_channel_lux_calculator_tb;
  import tclc_pkg::*;

  localparam int LATENCY = DEF_FRAC_BITS + 11;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_GAP = 16;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  sample_t sample = '0;
  logic    done;
  result_t result;

  int pending;
  int fail_count;
  int checked_count;
  int dark_hits;
  int curve_hits;
  int linear_hits;
  int cutoff_hits;
  int cycles = 0;
  int sent = 0;
  bit burst = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_channel_lux_calculator #(
    .POW_TABLE_DEPTH(DEF_POW_TABLE_DEPTH),
    .FRAC_BITS(DEF_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .done(done),
    .result(result)
  );

  lux_result_check #(
    .TABLE_DEPTH(DEF_POW_TABLE_DEPTH),
    .RATIO_FRAC(DEF_FRAC_BITS)
  ) lux_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .done(done),
    .result(result),
    .pending(pending),
    .fail_count(fail_count),
    .checked_count(checked_count),
    .dark_hits(dark_hits),
    .curve_hits(curve_hits),
    .linear_hits(linear_hits),
    .cutoff_hits(cutoff_hits)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one item at a falling edge, hold it until taken, then idle a random while, or not at all in a burst
  task automatic send_sample(input int c0, input int c1);
    int gap;
    sample <= '{broadband_count: c0[COUNT_W-1:0], infrared_count: c1[COUNT_W-1:0]};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int clamp_count(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  initial begin
    int c0;
    int c1;
    int bound;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners: zero and full counts, smallest ratios
    send_sample(0, 0);
    send_sample(0, 65535);
    send_sample(65535, 0);
    send_sample(65535, 65535);
    send_sample(1, 0);
    send_sample(1, 1);
    send_sample(1, 65535);
    send_sample(65535, 1);
    send_sample(2, 1);
    // each bound exactly and one count past it
    send_sample(100, 52);
    send_sample(100, 53);
    send_sample(100, 65);
    send_sample(100, 66);
    send_sample(100, 80);
    send_sample(100, 81);
    send_sample(100, 130);
    send_sample(100, 131);
    send_sample(65500, 34060);
    send_sample(65500, 42575);
    send_sample(65500, 52400);
    send_sample(65535, 34078);
    send_sample(65535, 34079);
    // k = 1.30 exactly: linear term cancels to zero
    send_sample(50000, 65000);
    send_sample(50000, 65001);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          c0 = $urandom_range(0, 65535);
          c1 = $urandom_range(0, 65535);
        end
        3, 4, 5, 6: begin
          // ratio spread over all segments and a bit past the cutoff
          c0 = $urandom_range(1, 65535);
          c1 = clamp_count(c0 * $urandom_range(0, 1400) / 1000);
        end
        7, 8: begin
          case ($urandom_range(0, 3))
            0: bound = BOUND_POW;
            1: bound = BOUND_LIN1;
            2: bound = BOUND_LIN2;
            default: bound = BOUND_LIN3;
          endcase
          c0 = RATIO_SCALE * $urandom_range(1, 500);
          c1 = clamp_count(c0 * bound / RATIO_SCALE + $urandom_range(0, 2) - 1);
        end
        default: begin
          c0 = $urandom_range(0, 15);
          c1 = $urandom_range(0, 31);
        end
      endcase
      send_sample(c0, c1);
    end
    start <= 1'b0;

    // drain, then allow for any stray strobe
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);

    $display("Sent %0d samples, %0d results compared against prediction.",
             sent, checked_count);
    $display("Zero-broadband %0d, power curve %0d, linear %0d, above 1.30 %0d.",
             dark_hits, curve_hits, linear_hits, cutoff_hits);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
